@@ rtl/core/boundary_tag_first_fit_allocator_assert.svh @@
// assertion macros for the boundary tag allocator checker
// both expect clk and rst_n in the scope of use
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_ASSERT_SVH

// consequent checked at the same edge as the antecedent
`define BTFF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked at the following edge
`define BTFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/btff_pkg.sv @@
`default_nettype none

package btff_pkg;

  localparam int HEAP_WORDS   = 4096;
  localparam int ADDR_W       = $clog2(HEAP_WORDS);
  localparam int SIZE_W       = ADDR_W + 1;
  localparam int TAG_W        = SIZE_W + 1;
  localparam int REQ_W        = 14;
  localparam int CFG_W        = 13;
  localparam int TAG_OVERHEAD = 2;
  localparam int MIN_HEAP     = 4;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [REQ_W-1:0]  req_t;
  typedef logic [CFG_W-1:0]  cfg_t;

  localparam logic CMD_ALLOC    = 1'b0;
  localparam logic CMD_FREE     = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_NOFIT = 1'b1;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLR_STEP,
    DP_LOAD,
    DP_A_READ,
    DP_A_CHK,
    DP_A_WF,
    DP_A_RH,
    DP_A_RF,
    DP_F_READ,
    DP_F_CHK,
    DP_F_WF,
    DP_F_NREAD,
    DP_F_NCHK,
    DP_F_NWH,
    DP_F_NWF,
    DP_F_PREAD,
    DP_F_PCHK,
    DP_F_HREAD,
    DP_F_PWH,
    DP_F_PWF,
    DP_RESULT
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_A_RD,
    ST_A_CHK,
    ST_A_WF,
    ST_A_RH,
    ST_A_RF,
    ST_F_TEST,
    ST_F_CHK,
    ST_F_WF,
    ST_F_NRD,
    ST_F_NCHK,
    ST_F_NWH,
    ST_F_NWF,
    ST_F_PRD,
    ST_F_PCHK,
    ST_F_HRD,
    ST_F_HCHK,
    ST_F_PWF,
    ST_FINISH
  } state_t;

  typedef struct packed {
    dp_op_t op;
    logic   cfg_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic p_in;
    logic a_bad;
    logic a_fit;
    logic a_split;
    logic f_in;
    logic f_ok;
    logic n_in;
    logic n_ok;
    logic at_zero;
    logic p_ok;
    logic ph_free;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/btff_in_if.sv @@
`default_nettype none

interface btff_in_if;
  import btff_pkg::*;

  logic  valid;
  logic  ready;
  logic  command;
  req_t  request_bytes;
  addr_t free_index;

  modport source (output valid, command, request_bytes, free_index, input ready);
  modport sink   (input valid, command, request_bytes, free_index, output ready);
endinterface

`default_nettype wire

@@ rtl/core/btff_out_if.sv @@
`default_nettype none

interface btff_out_if;
  import btff_pkg::*;

  logic  valid;
  logic  ready;
  logic  status;
  addr_t block_index;

  modport source (output valid, status, block_index, input ready);
  modport sink   (input valid, status, block_index, output ready);
endinterface

`default_nettype wire

@@ rtl/core/btff_cfg_if.sv @@
`default_nettype none

interface btff_cfg_if;
  import btff_pkg::*;

  logic valid;
  logic ready;
  cfg_t heap_words;

  modport source (output valid, heap_words, input ready);
  modport sink   (input valid, heap_words, output ready);
endinterface

`default_nettype wire

@@ rtl/core/boundary_tag_first_fit_allocator.sv @@
// channel   dir  words carried                               handshake
// in_ch     in   command, request_bytes, free_index           valid/ready
// out_ch    out  status, block_index                          valid/ready
// cfg_ch    in   heap_words                                   valid/ready
//
// allocate: a tag read and a check per block visited on the walk, a footer write
//   on a fit, two writes to split off a remainder, a last read off the arena end
// free: made of the header, next-neighbor and previous-neighbor reads
//   and tag writes, all through the single tag memory
// reset and every heap_words write start a clearing pass; in_ch held off
// one item at a time; a waiting result on out_ch only holds the next one at its end
`default_nettype none

module boundary_tag_first_fit_allocator (
  input wire          clk,
  input wire          rst_n,
  btff_in_if.sink     in_ch,
  btff_out_if.source  out_ch,
  btff_cfg_if.sink    cfg_ch
);
  import btff_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // config writes are always taken, they restart the clearing pass
  assign cfg_ch.ready = 1'b1;

  // sequencer: walk, split, coalesce and result handoff
  btff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cfg_valid (cfg_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // tag memory, walk pointer, sizes and result register
  btff_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_command       (in_ch.command),
    .in_request_bytes (in_ch.request_bytes),
    .in_free_index    (in_ch.free_index),
    .cfg_heap_words   (cfg_ch.heap_words),
    .res_status       (out_ch.status),
    .res_block_index  (out_ch.block_index)
  );

endmodule

`default_nettype wire

@@ rtl/core/btff_ctrl.sv @@
`default_nettype none

module btff_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire               out_ready,
  input  wire               cfg_valid,
  input  wire btff_pkg::dp_sts_t sts,
  output btff_pkg::dp_cmd_t cmd
);
  import btff_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = DP_NOP;
    cmd.cfg_wr = cfg_valid;
    in_ready   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.op = DP_CLR_STEP;
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = !cfg_valid;
        if (in_valid && !cfg_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = ST_START;
        end
      end
      ST_START: state_nxt = sts.is_free ? ST_F_TEST : ST_A_RD;
      // allocate walk
      ST_A_RD: begin
        cmd.op    = DP_A_READ;
        state_nxt = sts.p_in ? ST_A_CHK : ST_FINISH;
      end
      ST_A_CHK: begin
        cmd.op = DP_A_CHK;
        priority if (sts.a_bad) state_nxt = ST_FINISH;
        else if (sts.a_fit)     state_nxt = ST_A_WF;
        else                    state_nxt = ST_A_RD;
      end
      ST_A_WF: begin
        cmd.op    = DP_A_WF;
        state_nxt = sts.a_split ? ST_A_RH : ST_FINISH;
      end
      ST_A_RH: begin
        cmd.op    = DP_A_RH;
        state_nxt = ST_A_RF;
      end
      ST_A_RF: begin
        cmd.op    = DP_A_RF;
        state_nxt = ST_FINISH;
      end
      // free and coalesce
      ST_F_TEST: begin
        cmd.op    = DP_F_READ;
        state_nxt = sts.f_in ? ST_F_CHK : ST_FINISH;
      end
      ST_F_CHK: begin
        cmd.op    = DP_F_CHK;
        state_nxt = sts.f_ok ? ST_F_WF : ST_FINISH;
      end
      ST_F_WF: begin
        cmd.op    = DP_F_WF;
        state_nxt = sts.n_in ? ST_F_NRD : ST_F_PRD;
      end
      ST_F_NRD: begin
        cmd.op    = DP_F_NREAD;
        state_nxt = ST_F_NCHK;
      end
      ST_F_NCHK: begin
        cmd.op    = DP_F_NCHK;
        state_nxt = sts.n_ok ? ST_F_NWH : ST_F_PRD;
      end
      ST_F_NWH: begin
        cmd.op    = DP_F_NWH;
        state_nxt = ST_F_NWF;
      end
      ST_F_NWF: begin
        cmd.op    = DP_F_NWF;
        state_nxt = ST_F_PRD;
      end
      ST_F_PRD: begin
        cmd.op    = DP_F_PREAD;
        state_nxt = sts.at_zero ? ST_FINISH : ST_F_PCHK;
      end
      ST_F_PCHK: begin
        cmd.op    = DP_F_PCHK;
        state_nxt = sts.p_ok ? ST_F_HRD : ST_FINISH;
      end
      ST_F_HRD: begin
        cmd.op    = DP_F_HREAD;
        state_nxt = ST_F_HCHK;
      end
      ST_F_HCHK: begin
        cmd.op    = DP_F_PWH;
        state_nxt = sts.ph_free ? ST_F_PWF : ST_FINISH;
      end
      ST_F_PWF: begin
        cmd.op    = DP_F_PWF;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.op    = DP_RESULT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
    // new arena size restarts the clearing pass
    if (cfg_valid) begin
      cmd.op    = DP_NOP;
      state_nxt = ST_CLEAR;
    end
    out_valid_nxt = (out_valid_r && !out_ready) || (cmd.op == DP_RESULT);
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/core/btff_dp.sv @@
`default_nettype none

module btff_dp (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire btff_pkg::dp_cmd_t  cmd,
  output btff_pkg::dp_sts_t       sts,
  input  wire                     in_command,
  input  wire btff_pkg::req_t     in_request_bytes,
  input  wire btff_pkg::addr_t    in_free_index,
  input  wire btff_pkg::cfg_t     cfg_heap_words,
  output logic                    res_status,
  output btff_pkg::addr_t         res_block_index
);
  import btff_pkg::*;

  // tag store
  tag_t  mem [HEAP_WORDS];
  tag_t  rdata_r;
  logic  we;
  addr_t waddr, raddr;
  tag_t  wdata;

  size_t hw_r;
  addr_t clr_r;
  size_t p_r, need_r, size_r, psize_r;
  addr_t at_r;
  logic  free_cmd_r, fail_r;
  logic  res_status_r;
  addr_t res_index_r;

  size_t rd_size;
  logic  rd_used;
  size_t at_w, hw_minus_p, next_w, hw_clamp, clr_w, merged;
  size_t a_foot, a_rem, r_foot, f_foot, prev_w;
  logic [REQ_W:0] bytes_rnd;

  assign rd_size    = rdata_r[TAG_W-1:1];
  assign rd_used    = rdata_r[0];
  assign at_w       = {1'b0, at_r};
  assign clr_w      = {1'b0, clr_r};
  assign hw_minus_p = hw_r - p_r;
  assign next_w     = at_w + size_r;
  assign merged     = psize_r + size_r;
  assign a_foot     = p_r + need_r - SIZE_W'(1);
  assign a_rem      = p_r + need_r;
  assign r_foot     = p_r + size_r - SIZE_W'(1);
  assign f_foot     = at_w + size_r - SIZE_W'(1);
  assign prev_w     = at_w - psize_r;
  assign bytes_rnd  = {1'b0, in_request_bytes} + (REQ_W+1)'(3);

  always_comb begin
    priority if (cfg_heap_words < CFG_W'(MIN_HEAP))   hw_clamp = SIZE_W'(MIN_HEAP);
    else if (cfg_heap_words > CFG_W'(HEAP_WORDS))     hw_clamp = SIZE_W'(HEAP_WORDS);
    else                                              hw_clamp = SIZE_W'(cfg_heap_words);
  end

  always_comb begin
    sts.clr_done = &clr_r;
    sts.is_free  = free_cmd_r;
    sts.p_in     = p_r < hw_r;
    sts.a_bad    = (rd_size == '0) || (rd_size > hw_minus_p);
    sts.a_fit    = !rd_used && (rd_size >= need_r);
    sts.a_split  = size_r > need_r;
    sts.f_in     = at_w < hw_r;
    sts.f_ok     = rd_used && (rd_size != '0) && (rd_size <= hw_r - at_w);
    sts.n_in     = next_w < hw_r;
    sts.n_ok     = !rd_used && (rd_size != '0) && (rd_size <= hw_r - next_w);
    sts.at_zero  = at_r == '0;
    sts.p_ok     = (rd_size != '0) && (rd_size <= at_w);
    sts.ph_free  = !rd_used;
  end

  // memory address and data select
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (cmd.op)
      DP_CLR_STEP: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = (clr_w == '0 || clr_w == hw_r - SIZE_W'(1)) ? {hw_r, 1'b0} : '0;
      end
      DP_A_READ:  raddr = p_r[ADDR_W-1:0];
      DP_A_CHK: begin
        we    = !sts.a_bad && sts.a_fit;
        waddr = p_r[ADDR_W-1:0];
        wdata = {need_r, 1'b1};
      end
      DP_A_WF: begin
        we    = 1'b1;
        waddr = a_foot[ADDR_W-1:0];
        wdata = {need_r, 1'b1};
      end
      DP_A_RH: begin
        we    = 1'b1;
        waddr = a_rem[ADDR_W-1:0];
        wdata = {size_r - need_r, 1'b0};
      end
      DP_A_RF: begin
        we    = 1'b1;
        waddr = r_foot[ADDR_W-1:0];
        wdata = {size_r - need_r, 1'b0};
      end
      DP_F_READ:  raddr = at_r;
      DP_F_CHK: begin
        we    = sts.f_ok;
        waddr = at_r;
        wdata = {rd_size, 1'b0};
      end
      DP_F_WF, DP_F_NWF: begin
        we    = 1'b1;
        waddr = f_foot[ADDR_W-1:0];
        wdata = {size_r, 1'b0};
      end
      DP_F_NREAD: raddr = next_w[ADDR_W-1:0];
      DP_F_NWH: begin
        we    = 1'b1;
        waddr = at_r;
        wdata = {size_r, 1'b0};
      end
      DP_F_PREAD: raddr = at_r - ADDR_W'(1);
      DP_F_HREAD: raddr = prev_w[ADDR_W-1:0];
      DP_F_PWH: begin
        we    = sts.ph_free;
        waddr = prev_w[ADDR_W-1:0];
        wdata = {merged, 1'b0};
      end
      DP_F_PWF: begin
        we    = 1'b1;
        waddr = f_foot[ADDR_W-1:0];
        wdata = {merged, 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r  <= SIZE_W'(HEAP_WORDS);
      clr_r <= '0;
    end else if (cmd.cfg_wr) begin
      hw_r  <= hw_clamp;
      clr_r <= '0;
    end else if (cmd.op == DP_CLR_STEP) begin
      clr_r <= clr_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        free_cmd_r <= (in_command == CMD_FREE);
        need_r     <= bytes_rnd[REQ_W:2] + SIZE_W'(TAG_OVERHEAD);
        at_r       <= in_free_index;
        p_r        <= '0;
        fail_r     <= 1'b0;
      end
      DP_A_READ: if (!sts.p_in) fail_r <= 1'b1;
      DP_A_CHK: begin
        priority if (sts.a_bad) fail_r <= 1'b1;
        else if (sts.a_fit)     size_r <= rd_size;
        else                    p_r    <= p_r + rd_size;
      end
      DP_F_CHK:  size_r <= rd_size;
      DP_F_NCHK: if (sts.n_ok) size_r <= size_r + rd_size;
      DP_F_PCHK: psize_r <= rd_size;
      DP_RESULT: begin
        res_status_r <= fail_r ? STATUS_NOFIT : STATUS_OK;
        res_index_r  <= (fail_r || free_cmd_r) ? '0 : p_r[ADDR_W-1:0];
      end
      default: ;
    endcase
  end

  assign res_status      = res_status_r;
  assign res_block_index = res_index_r;

endmodule

`default_nettype wire

@@ rtl/core/btff_sva.sv @@
`default_nettype none

`include "boundary_tag_first_fit_allocator_assert.svh"

module btff_sva (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire                  out_status,
  input wire btff_pkg::addr_t out_block_index,
  input wire                  cfg_valid,
  input wire                  cfg_ready
);
  import btff_pkg::*;

  `BTFF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")
  `BTFF_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_status) && $stable(out_block_index), "result word changed while stalled")
  `BTFF_ASSERT_SAME(a_nofit_index, out_valid && (out_status == STATUS_NOFIT), out_block_index == '0, "no-fit result with nonzero index")
  `BTFF_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "second word taken before first finished")
  `BTFF_ASSERT_NEXT(a_clear_after_cfg, cfg_valid && cfg_ready, !in_ready, "word taken during arena clear")

endmodule

bind boundary_tag_first_fit_allocator btff_sva u_btff_sva (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_block_index (out_ch.block_index),
  .cfg_valid       (cfg_ch.valid),
  .cfg_ready       (cfg_ch.ready)
);

`default_nettype wire
